[hdl/fac_pkg.sv]
package fac_pkg;

  localparam int COORD_W   = 32;
  localparam int NORM_W    = COORD_W + 1;
  localparam int PROD_W    = NORM_W + COORD_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int DIST_SH   = 16;
  localparam int PLANE_CNT = 6;
  localparam int AXIS_CNT  = 3;
  localparam int MAT_AW    = 4;
  localparam int MAT_SIZE  = 1 << MAT_AW;
  localparam int MQ_AW     = 2;
  localparam int MQ_DEPTH  = 1 << MQ_AW;
  localparam int OQ_AW     = 3;
  localparam int OQ_DEPTH  = 1 << OQ_AW;
  localparam int LAST_IDX  = 3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_BOX  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // one decoded item on its way from the front to the back
  typedef struct packed {
    logic                    is_box;
    logic [MAT_AW-1:0]       addr;
    coord_t                  value;
    coord_t [AXIS_CNT-1:0]   bmin;
    coord_t [AXIS_CNT-1:0]   bmax;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } mq_head_t;

  typedef struct packed {
    logic push;
    logic visible;
  } res_t;

  // matrix storage index: column first, then row
  function automatic logic [MAT_AW-1:0] mat_idx(input logic [1:0] col, input logic [1:0] row);
    return {col, row};
  endfunction

endpackage

[hdl/fac_front.sv]
module fac_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_kind,
  input  logic [1:0]        in_matrix_col,
  input  logic [1:0]        in_matrix_row,
  input  logic signed [31:0] in_matrix_value,
  input  logic signed [31:0] in_min_x,
  input  logic signed [31:0] in_min_y,
  input  logic signed [31:0] in_min_z,
  input  logic signed [31:0] in_max_x,
  input  logic signed [31:0] in_max_y,
  input  logic signed [31:0] in_max_z,
  output fac_pkg::mq_head_t head,
  input  logic              head_pop
);
  import fac_pkg::*;

  cmd_t             mem_r [MQ_DEPTH];
  logic [MQ_AW-1:0] wr_ptr_r;
  logic [MQ_AW-1:0] rd_ptr_r;
  logic [MQ_AW:0]   count_r;
  cmd_t             cmd_in;
  logic             push_ok;
  logic             pop_ok;

  // classify the incoming item
  always_comb begin
    cmd_in         = '0;
    cmd_in.is_box  = (in_kind == KIND_BOX);
    cmd_in.addr    = mat_idx(in_matrix_col, in_matrix_row);
    cmd_in.value   = in_matrix_value;
    cmd_in.bmin[0] = in_min_x;
    cmd_in.bmin[1] = in_min_y;
    cmd_in.bmin[2] = in_min_z;
    cmd_in.bmax[0] = in_max_x;
    cmd_in.bmax[1] = in_max_y;
    cmd_in.bmax[2] = in_max_z;
  end

  assign in_full    = (count_r == (MQ_AW+1)'(MQ_DEPTH));
  assign push_ok    = in_push && !in_full;
  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];
  assign pop_ok     = head_pop && head.valid;

  // store the item in the queue
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hdl/fac_back.sv]
module fac_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fac_pkg::mq_head_t       head,
  output logic                    head_pop,
  input  logic [fac_pkg::OQ_AW:0] oq_count,
  output fac_pkg::res_t           res
);
  import fac_pkg::*;

  coord_t mat_r [MAT_SIZE];

  norm_t  n_nxt  [PLANE_CNT][AXIS_CNT];
  norm_t  d_nxt  [PLANE_CNT];
  coord_t pt_nxt [PLANE_CNT][AXIS_CNT];

  norm_t  n_a_r  [PLANE_CNT][AXIS_CNT];
  norm_t  d_a_r  [PLANE_CNT];
  coord_t pt_a_r [PLANE_CNT][AXIS_CNT];
  logic   valid_a_r;

  prod_t  prod_b_r [PLANE_CNT][AXIS_CNT];
  norm_t  d_b_r    [PLANE_CNT];
  logic   valid_b_r;

  acc_t   sum_a_r [PLANE_CNT];
  acc_t   sum_b_r [PLANE_CNT];
  logic   valid_c_r;

  logic [1:0]       inflight;
  logic [OQ_AW+1:0] occ;
  logic             credit;
  logic             issue;
  logic             box_go;
  logic             vis;
  acc_t             tot;

  // issue a box only when the result queue has room for every box in flight; loads always issue
  assign inflight = 2'(valid_a_r) + 2'(valid_b_r) + 2'(valid_c_r);
  assign occ      = (OQ_AW+2)'(oq_count) + (OQ_AW+2)'(inflight);
  assign credit   = (occ < (OQ_AW+2)'(OQ_DEPTH));
  assign issue    = head.valid && (!head.cmd.is_box || credit);
  assign box_go   = issue && head.cmd.is_box;
  assign head_pop = issue;

  // write one matrix element per load item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_SIZE; i++) begin
        mat_r[i] <= '0;
      end
    end else if (issue && !head.cmd.is_box) begin
      mat_r[head.cmd.addr] <= head.cmd.value;
    end
  end

  // derive planes (row 3 plus or minus row src) and pick the far corner
  always_comb begin
    for (int p = 0; p < PLANE_CNT; p++) begin
      for (int c = 0; c < AXIS_CNT; c++) begin
        if ((p & 1) != 0) begin
          n_nxt[p][c] = norm_t'(mat_r[mat_idx(2'(c), 2'(LAST_IDX))])
                      - norm_t'(mat_r[mat_idx(2'(c), 2'(p >> 1))]);
        end else begin
          n_nxt[p][c] = norm_t'(mat_r[mat_idx(2'(c), 2'(LAST_IDX))])
                      + norm_t'(mat_r[mat_idx(2'(c), 2'(p >> 1))]);
        end
        pt_nxt[p][c] = n_nxt[p][c][NORM_W-1] ? head.cmd.bmin[c] : head.cmd.bmax[c];
      end
      if ((p & 1) != 0) begin
        d_nxt[p] = norm_t'(mat_r[mat_idx(2'(LAST_IDX), 2'(LAST_IDX))])
                 - norm_t'(mat_r[mat_idx(2'(LAST_IDX), 2'(p >> 1))]);
      end else begin
        d_nxt[p] = norm_t'(mat_r[mat_idx(2'(LAST_IDX), 2'(LAST_IDX))])
                 + norm_t'(mat_r[mat_idx(2'(LAST_IDX), 2'(p >> 1))]);
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
      valid_c_r <= 1'b0;
    end else begin
      valid_a_r <= box_go;
      valid_b_r <= valid_a_r;
      valid_c_r <= valid_b_r;
    end
  end

  // hold plane coefficients and corners
  always_ff @(posedge clk) begin
    n_a_r  <= n_nxt;
    d_a_r  <= d_nxt;
    pt_a_r <= pt_nxt;
  end

  // multiply normal components by corner coordinates
  always_ff @(posedge clk) begin
    for (int p = 0; p < PLANE_CNT; p++) begin
      for (int c = 0; c < AXIS_CNT; c++) begin
        prod_b_r[p][c] <= prod_t'(n_a_r[p][c]) * prod_t'(pt_a_r[p][c]);
      end
      d_b_r[p] <= d_a_r[p];
    end
  end

  // partial sums; distance is aligned to the Q32.32 products
  always_ff @(posedge clk) begin
    for (int p = 0; p < PLANE_CNT; p++) begin
      sum_a_r[p] <= acc_t'(prod_b_r[p][0]) + acc_t'(prod_b_r[p][1]);
      sum_b_r[p] <= acc_t'(prod_b_r[p][2]) + (acc_t'(d_b_r[p]) <<< DIST_SH);
    end
  end

  // final sum and sign test per plane
  always_comb begin
    vis = 1'b1;
    tot = '0;
    for (int p = 0; p < PLANE_CNT; p++) begin
      tot = sum_a_r[p] + sum_b_r[p];
      if (tot[ACC_W-1]) begin
        vis = 1'b0;
      end
    end
  end

  assign res.push    = valid_c_r;
  assign res.visible = vis;

endmodule

[hdl/fac_outq.sv]
module fac_outq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fac_pkg::res_t            res,
  output logic [fac_pkg::OQ_AW:0]  oq_count,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic                     out_visible
);
  import fac_pkg::*;

  logic             mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r;
  logic [OQ_AW-1:0] rd_ptr_r;
  logic [OQ_AW:0]   count_r;
  logic             pop_ok;

  assign out_empty   = (count_r == '0);
  assign out_visible = mem_r[rd_ptr_r];
  assign oq_count    = count_r;
  assign pop_ok      = out_pop && !out_empty;

  // store each finished result
  always_ff @(posedge clk) begin
    if (res.push) begin
      mem_r[wr_ptr_r] <= res.visible;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (res.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({res.push, pop_ok})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hdl/frustum_aabb_cull.sv]
// Path: a box item passes the 4-entry input queue, behind any items queued ahead
//   of it, then the plane, multiply and sum registers, on to the result queue.
// Throughput: one item per cycle, loads and boxes alike, except that a box waits
//   while the 3-stage plane/multiply/sum pipeline and the 8-entry result queue
//   already hold 8 results. Load items write the matrix and give no result.
// Reset (rst_n low, synchronous) clears the matrix to zero and empties both queues.
module frustum_aabb_cull (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_kind,
  input  logic [1:0]         in_matrix_col,
  input  logic [1:0]         in_matrix_row,
  input  logic signed [31:0] in_matrix_value,
  input  logic signed [31:0] in_min_x,
  input  logic signed [31:0] in_min_y,
  input  logic signed [31:0] in_min_z,
  input  logic signed [31:0] in_max_x,
  input  logic signed [31:0] in_max_y,
  input  logic signed [31:0] in_max_z,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_visible
);
  import fac_pkg::*;

  mq_head_t         head;
  logic             head_pop;
  res_t             res;
  logic [OQ_AW:0]   oq_count;

  fac_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_kind         (in_kind),
    .in_matrix_col   (in_matrix_col),
    .in_matrix_row   (in_matrix_row),
    .in_matrix_value (in_matrix_value),
    .in_min_x        (in_min_x),
    .in_min_y        (in_min_y),
    .in_min_z        (in_min_z),
    .in_max_x        (in_max_x),
    .in_max_y        (in_max_y),
    .in_max_z        (in_max_z),
    .head            (head),
    .head_pop        (head_pop)
  );

  fac_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_pop (head_pop),
    .oq_count (oq_count),
    .res      (res)
  );

  fac_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .res         (res),
    .oq_count    (oq_count),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_visible (out_visible)
  );

endmodule

[hdl/fac_chk.sv]
module fac_chk (
  input logic clk,
  input logic rst_n,
  input logic in_push,
  input logic in_full,
  input logic in_kind,
  input logic out_empty,
  input logic out_pop,
  input logic out_visible
);
  import fac_pkg::*;

  logic [4:0] pend_r;
  logic       loaded_r;
  logic       box_acc;
  logic       load_acc;
  logic       res_acc;

  assign box_acc  = in_push && !in_full && (in_kind == KIND_BOX);
  assign load_acc = in_push && !in_full && (in_kind == KIND_LOAD);
  assign res_acc  = out_pop && !out_empty;

  // track boxes whose result has not been taken, and whether any load happened
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      loaded_r <= 1'b0;
    end else begin
      pend_r <= pend_r + 5'(box_acc) - 5'(res_acc);
      if (load_acc) begin
        loaded_r <= 1'b1;
      end
    end
  end

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> pend_r != '0)
    else $error("result shown with no box pending");

  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (box_acc && pend_r == '0) |=> out_empty ##1 out_empty ##1 out_empty)
    else $error("result appeared before the pipeline could finish");

  a_zero_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !loaded_r) |-> out_visible)
    else $error("box culled by a matrix that was never loaded");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_visible))
    else $error("waiting result changed");

endmodule

bind frustum_aabb_cull fac_chk u_chk (.*);
